// ===== hdl/pscb_pkg.sv =====
// ----------------------------------------------------------------------------
// Pretrigger speech capture buffer package
// Shared widths, operation and register codes, and the control structs that
// pass between the controller and the two storage units.
// ----------------------------------------------------------------------------
package pscb_pkg;

   localparam int SAMPLE_W     = 16;
   localparam int INDEX_W      = 16;
   localparam int OP_W         = 3;
   localparam int PRE_LEN_W    = 14;
   localparam int MAX_SMP_W    = 17;
   localparam int COUNT_W      = 17;
   localparam int CSR_IDX_W    = 1;
   localparam int CSR_DATA_W   = 17;
   localparam int REQ_TDATA_W  = 32;
   localparam int RSP_TDATA_W  = 40;
   localparam int RSP_PAD_W    = RSP_TDATA_W - SAMPLE_W - COUNT_W - 3;

   localparam logic [PRE_LEN_W-1:0] PRE_LEN_RESET = 14'd8192;
   localparam logic [MAX_SMP_W-1:0] MAX_SMP_RESET = 17'd65536;

   typedef enum logic [OP_W-1:0] {
      OP_SAMPLE       = 3'd0,
      OP_SPEECH_START = 3'd1,
      OP_SPEECH_END   = 3'd2,
      OP_READ         = 3'd3,
      OP_LISTEN_START = 3'd4,
      OP_LISTEN_STOP  = 3'd5
   } op_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_PREROLL_LENGTH = 1'b0,
      CSR_MAX_SAMPLES    = 1'b1
   } csr_reg_type;

   // Pre-roll ring controls.
   typedef struct packed {
      logic push;
      logic clear;
      logic copy_load;
      logic copy_step;
   } ring_ctrl_type;

   // Capture memory controls.
   typedef struct packed {
      logic clear;
      logic write;
      logic read;
   } cap_ctrl_type;

endpackage

// ===== hdl/pscb_ring.sv =====
// ----------------------------------------------------------------------------
// Pre-roll ring
// Holds the most recent samples in a circular memory, tracks the write
// position and wrap state, and walks the ring oldest-first for a copy.
// ----------------------------------------------------------------------------
module pscb_ring #(
   parameter int PREROLL_DEPTH = 8192
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pscb_pkg::ring_ctrl_type       ctrl,
   input  logic [pscb_pkg::SAMPLE_W-1:0] push_data,
   input  logic [$clog2(PREROLL_DEPTH+1)-1:0] ring_len,
   output logic [$clog2(PREROLL_DEPTH+1)-1:0] copy_total,
   output logic [pscb_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int PW  = (PREROLL_DEPTH > 1) ? $clog2(PREROLL_DEPTH) : 1;
   localparam int RLW = $clog2(PREROLL_DEPTH + 1);

   logic [pscb_pkg::SAMPLE_W-1:0] mem [PREROLL_DEPTH];

   logic [PW-1:0]  pos_ff, pos_in;
   logic           wrapped_ff, wrapped_in;
   logic [PW-1:0]  rd_addr_ff, rd_addr_in;
   logic           wrap_en_ff, wrap_en_in;
   logic [RLW-1:0] pos_inc;
   logic [RLW-1:0] rd_inc;
   logic           wrap_en;
   logic [pscb_pkg::SAMPLE_W-1:0] rd_data_ff;

   // A wrapped ring whose length still covers the write position holds its
   // oldest entries from the write position to the end.
   assign wrap_en    = wrapped_ff && (ring_len > RLW'(pos_ff));
   assign copy_total = wrap_en ? ring_len : RLW'(pos_ff);
   assign pos_inc    = RLW'(pos_ff) + RLW'(1);
   assign rd_inc     = RLW'(rd_addr_ff) + RLW'(1);
   assign rd_data    = rd_data_ff;

   always_comb begin
      pos_in     = pos_ff;
      wrapped_in = wrapped_ff;
      rd_addr_in = rd_addr_ff;
      wrap_en_in = wrap_en_ff;
      if (ctrl.clear) begin
         pos_in     = '0;
         wrapped_in = 1'b0;
      end else if (ctrl.push) begin
         if (pos_inc >= ring_len) begin
            pos_in     = '0;
            wrapped_in = 1'b1;
         end else begin
            pos_in = PW'(pos_inc);
         end
      end
      if (ctrl.copy_load) begin
         rd_addr_in = wrap_en ? pos_ff : '0;
         wrap_en_in = wrap_en;
      end else if (ctrl.copy_step) begin
         if (wrap_en_ff && (rd_inc == ring_len)) begin
            rd_addr_in = '0;
            wrap_en_in = 1'b0;
         end else begin
            rd_addr_in = PW'(rd_inc);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff     <= '0;
         wrapped_ff <= 1'b0;
         rd_addr_ff <= '0;
         wrap_en_ff <= 1'b0;
      end else begin
         pos_ff     <= pos_in;
         wrapped_ff <= wrapped_in;
         rd_addr_ff <= rd_addr_in;
         wrap_en_ff <= wrap_en_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.push) begin
         mem[pos_ff] <= push_data;
      end
      if (ctrl.copy_step) begin
         rd_data_ff <= mem[rd_addr_ff];
      end
   end

endmodule

// ===== hdl/pscb_capture.sv =====
// ----------------------------------------------------------------------------
// Capture memory
// Appends samples up to the capture limit, keeps the captured count and
// serves registered reads by index.
// ----------------------------------------------------------------------------
module pscb_capture #(
   parameter int CAPTURE_DEPTH = 65536
) (
   input  logic                          clock,
   input  logic                          reset,
   input  pscb_pkg::cap_ctrl_type        ctrl,
   input  logic [pscb_pkg::SAMPLE_W-1:0] wr_data,
   input  logic [pscb_pkg::INDEX_W-1:0]  rd_index,
   input  logic [$clog2(CAPTURE_DEPTH+1)-1:0] cap_limit,
   output logic [$clog2(CAPTURE_DEPTH+1)-1:0] count,
   output logic [$clog2(CAPTURE_DEPTH+1)-1:0] count_next,
   output logic                          room,
   output logic [pscb_pkg::SAMPLE_W-1:0] rd_data
);

   localparam int AW  = $clog2(CAPTURE_DEPTH);
   localparam int CLW = $clog2(CAPTURE_DEPTH + 1);

   logic [pscb_pkg::SAMPLE_W-1:0] mem [CAPTURE_DEPTH];

   logic [CLW-1:0] count_ff, count_in;
   logic [pscb_pkg::SAMPLE_W-1:0] rd_data_ff;
   logic           do_write;

   // The limit never exceeds the depth, so a count below it is a valid address.
   assign room       = count_ff < cap_limit;
   assign do_write   = ctrl.write && room;
   assign count      = count_ff;
   assign count_next = count_in;
   assign rd_data    = rd_data_ff;

   always_comb begin
      count_in = count_ff;
      if (ctrl.clear) begin
         count_in = '0;
      end else if (do_write) begin
         count_in = count_ff + CLW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_write) begin
         mem[count_ff[AW-1:0]] <= wr_data;
      end
      if (ctrl.read) begin
         rd_data_ff <= mem[AW'(rd_index)];
      end
   end

endmodule

// ===== hdl/pretrigger_speech_capture_buffer.sv =====
// ----------------------------------------------------------------------------
// Pretrigger speech capture buffer
// Speech-triggered audio capture with a pre-roll ring, a capture memory and
// indexed read-back, driven by one operation per request transaction.
// ----------------------------------------------------------------------------
// Each request transaction carries one operation: an audio sample, speech
// start, speech end, a read, start listening or stop listening. Every request
// produces exactly one response transaction with the read data (zero unless a
// read hits a captured sample), the captured count and the speech, limit and
// listening flags as they stand after the operation. An ordinary request is
// accepted in ST_IDLE and executed against the memories in ST_EXEC, and while
// the response port keeps up the block goes back to ST_IDLE for the next
// request; a finished response waits in the output register while the next
// request is accepted. Speech start while idle also copies the pre-roll ring
// into the capture memory oldest-first at one entry per cycle through the
// ring's single read port. Both memories come up undefined and need no
// clearing pass after reset. The configuration port is always ready, takes
// preroll_length (index 0) and max_samples (index 1), and is meant to be
// written only while no request is in flight. Out-of-range values are clamped
// to the storage depths, and zero acts as one.
// ----------------------------------------------------------------------------
module pretrigger_speech_capture_buffer #(
   parameter int PREROLL_DEPTH = 8192,
   parameter int CAPTURE_DEPTH = 65536
) (
   input  logic                              clock,
   input  logic                              reset,
   // Request channel.
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [pscb_pkg::REQ_TDATA_W-1:0]  req_tdata,  // sample[15:0], read_index[31:16]
   input  logic [pscb_pkg::OP_W-1:0]         req_tuser,  // opcode[2:0]
   input  logic                              req_tlast,  // block_end
   // Response channel.
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // read_data[15:0], captured_count[32:16], speech_active[33], limit_reached[34],
   // listening_on[35], zero padding[39:36]
   output logic [pscb_pkg::RSP_TDATA_W-1:0]  rsp_tdata,
   // Configuration write channel.
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [pscb_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [pscb_pkg::CSR_DATA_W-1:0]   csr_data
);

   localparam int RLW   = $clog2(PREROLL_DEPTH + 1);
   localparam int CLW   = $clog2(CAPTURE_DEPTH + 1);
   localparam int PL_CW = (RLW > pscb_pkg::PRE_LEN_W) ? RLW : pscb_pkg::PRE_LEN_W;
   localparam int MS_CW = (CLW > pscb_pkg::MAX_SMP_W) ? CLW : pscb_pkg::MAX_SMP_W;
   localparam int RI_CW = (CLW > pscb_pkg::INDEX_W) ? CLW : pscb_pkg::INDEX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_COPY,
      ST_DONE
   } state_type;

   // Configuration registers and their clamped views.
   logic [pscb_pkg::PRE_LEN_W-1:0] preroll_len_ff, preroll_len_in;
   logic [pscb_pkg::MAX_SMP_W-1:0] max_samples_ff, max_samples_in;
   logic [RLW-1:0] ring_len;
   logic [CLW-1:0] cap_limit;

   // Controller state.
   state_type      state_ff, state_in;
   logic           listening_ff, listening_in;
   logic           recording_ff, recording_in;
   logic           hit_limit_ff, hit_limit_in;
   logic [RLW-1:0] remaining_ff, remaining_in;
   logic           step_d_ff, step_d_in;

   // Accepted request.
   pscb_pkg::op_type              op_ff, op_in;
   logic [pscb_pkg::SAMPLE_W-1:0] sample_ff, sample_in;
   logic                          last_ff, last_in;
   logic [pscb_pkg::INDEX_W-1:0]  rindex_ff, rindex_in;

   // Response register.
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [pscb_pkg::SAMPLE_W-1:0] rsp_rdata_ff, rsp_rdata_in;
   logic [pscb_pkg::COUNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic                          rsp_active_ff, rsp_active_in;
   logic                          rsp_limit_ff, rsp_limit_in;
   logic                          rsp_listen_ff, rsp_listen_in;
   logic [pscb_pkg::SAMPLE_W-1:0] res_rdata_ff, res_rdata_in;

   // Storage interfaces.
   pscb_pkg::ring_ctrl_type       ring_ctrl;
   pscb_pkg::cap_ctrl_type        cap_ctrl;
   logic [RLW-1:0]                copy_total;
   logic [pscb_pkg::SAMPLE_W-1:0] ring_rd_data;
   logic [pscb_pkg::SAMPLE_W-1:0] cap_wr_data;
   logic [CLW-1:0]                cap_count;
   logic [CLW-1:0]                cap_count_next;
   logic                          cap_room;
   logic [pscb_pkg::SAMPLE_W-1:0] cap_rd_data;

   logic req_accept;
   logic out_free;
   logic out_load;
   logic out_from_exec;
   logic read_hit;
   logic [pscb_pkg::SAMPLE_W-1:0] exec_rdata;

   assign csr_ready  = 1'b1;
   assign req_tready = (state_ff == ST_IDLE);
   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{pscb_pkg::RSP_PAD_W{1'b0}}, rsp_listen_ff, rsp_limit_ff,
                        rsp_active_ff, rsp_count_ff, rsp_rdata_ff};

   // Clamp the ring length into one to the ring depth.
   always_comb begin
      if (preroll_len_ff == '0) begin
         ring_len = RLW'(1);
      end else if (PL_CW'(preroll_len_ff) > PL_CW'(PREROLL_DEPTH)) begin
         ring_len = RLW'(PREROLL_DEPTH);
      end else begin
         ring_len = RLW'(preroll_len_ff);
      end
   end

   // Clamp the capture limit into one to the capture depth.
   always_comb begin
      if (max_samples_ff == '0) begin
         cap_limit = CLW'(1);
      end else if (MS_CW'(max_samples_ff) > MS_CW'(CAPTURE_DEPTH)) begin
         cap_limit = CLW'(CAPTURE_DEPTH);
      end else begin
         cap_limit = CLW'(max_samples_ff);
      end
   end

   always_comb begin
      preroll_len_in = preroll_len_ff;
      max_samples_in = max_samples_ff;
      if (csr_valid) begin
         case (pscb_pkg::csr_reg_type'(csr_index))
            pscb_pkg::CSR_PREROLL_LENGTH: begin
               preroll_len_in = csr_data[pscb_pkg::PRE_LEN_W-1:0];
            end
            pscb_pkg::CSR_MAX_SAMPLES: begin
               max_samples_in = csr_data[pscb_pkg::MAX_SMP_W-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   // A read only returns data for an index below the captured count.
   assign read_hit   = RI_CW'(rindex_ff) < RI_CW'(cap_count);
   assign exec_rdata = (op_ff == pscb_pkg::OP_READ && read_hit) ? cap_rd_data : '0;

   always_comb begin
      state_in      = state_ff;
      listening_in  = listening_ff;
      recording_in  = recording_ff;
      hit_limit_in  = hit_limit_ff;
      remaining_in  = remaining_ff;
      step_d_in     = 1'b0;
      op_in         = op_ff;
      sample_in     = sample_ff;
      last_in       = last_ff;
      rindex_in     = rindex_ff;
      res_rdata_in  = res_rdata_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;
      rsp_rdata_in  = rsp_rdata_ff;
      rsp_active_in = rsp_active_ff;
      rsp_limit_in  = rsp_limit_ff;
      rsp_listen_in = rsp_listen_ff;
      out_load      = 1'b0;
      out_from_exec = 1'b0;
      ring_ctrl     = '0;
      cap_ctrl      = '0;
      cap_wr_data   = sample_ff;

      // The capture read is issued with the request so its data is ready
      // in the execute cycle.
      cap_ctrl.read = req_accept;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               op_in     = pscb_pkg::op_type'(req_tuser);
               sample_in = req_tdata[pscb_pkg::SAMPLE_W-1:0];
               last_in   = req_tlast;
               rindex_in = req_tdata[pscb_pkg::REQ_TDATA_W-1:pscb_pkg::SAMPLE_W];
               state_in  = ST_EXEC;
            end
         end
         ST_EXEC: begin
            case (op_ff)
               pscb_pkg::OP_SAMPLE: begin
                  if (listening_ff) begin
                     if (!recording_ff) begin
                        ring_ctrl.push = 1'b1;
                     end else begin
                        cap_ctrl.write = 1'b1;
                        // The utterance closes at a block end once the memory
                        // is full, counting the sample being appended.
                        if (last_ff && (!cap_room || (cap_count + CLW'(1) == cap_limit))) begin
                           recording_in    = 1'b0;
                           hit_limit_in    = 1'b1;
                           ring_ctrl.clear = 1'b1;
                        end
                     end
                  end
               end
               pscb_pkg::OP_SPEECH_START: begin
                  if (!recording_ff) begin
                     recording_in        = 1'b1;
                     cap_ctrl.clear      = 1'b1;
                     ring_ctrl.copy_load = 1'b1;
                     remaining_in        = copy_total;
                  end
               end
               pscb_pkg::OP_SPEECH_END: begin
                  if (recording_ff) begin
                     recording_in    = 1'b0;
                     ring_ctrl.clear = 1'b1;
                  end
               end
               pscb_pkg::OP_LISTEN_START: begin
                  if (!listening_ff) begin
                     ring_ctrl.clear = 1'b1;
                     cap_ctrl.clear  = 1'b1;
                     recording_in    = 1'b0;
                     hit_limit_in    = 1'b0;
                     listening_in    = 1'b1;
                  end
               end
               pscb_pkg::OP_LISTEN_STOP: begin
                  if (listening_ff) begin
                     listening_in = 1'b0;
                     recording_in = 1'b0;
                  end
               end
               default: begin
               end
            endcase
            res_rdata_in = exec_rdata;
            if (ring_ctrl.copy_load) begin
               state_in = ST_COPY;
            end else if (out_free) begin
               out_load      = 1'b1;
               out_from_exec = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_rdata_in  = exec_rdata;
               rsp_active_in = recording_in;
               rsp_limit_in  = hit_limit_in;
               rsp_listen_in = listening_in;
               state_in      = ST_IDLE;
            end else begin
               state_in = ST_DONE;
            end
         end
         ST_COPY: begin
            // Each ring read is written to the capture memory in the cycle after it; the
            // capture memory drops whatever lies beyond the limit.
            if (remaining_ff != '0) begin
               ring_ctrl.copy_step = 1'b1;
               remaining_in        = remaining_ff - RLW'(1);
               step_d_in           = 1'b1;
            end
            if (step_d_ff) begin
               cap_ctrl.write = 1'b1;
               cap_wr_data    = ring_rd_data;
            end
            if (remaining_ff == '0 && !step_d_ff) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               out_load      = 1'b1;
               rsp_valid_in  = 1'b1;
               rsp_rdata_in  = res_rdata_ff;
               rsp_active_in = recording_ff;
               rsp_limit_in  = hit_limit_ff;
               rsp_listen_in = listening_ff;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The count reported leaves the capture unit after this cycle's update
   // when the response goes out straight from execution.
   always_comb begin
      rsp_count_in = rsp_count_ff;
      if (out_load) begin
         rsp_count_in = out_from_exec ? pscb_pkg::COUNT_W'(cap_count_next)
                                      : pscb_pkg::COUNT_W'(cap_count);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         listening_ff   <= 1'b0;
         recording_ff   <= 1'b0;
         hit_limit_ff   <= 1'b0;
         remaining_ff   <= '0;
         step_d_ff      <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         preroll_len_ff <= pscb_pkg::PRE_LEN_RESET;
         max_samples_ff <= pscb_pkg::MAX_SMP_RESET;
      end else begin
         state_ff       <= state_in;
         listening_ff   <= listening_in;
         recording_ff   <= recording_in;
         hit_limit_ff   <= hit_limit_in;
         remaining_ff   <= remaining_in;
         step_d_ff      <= step_d_in;
         rsp_valid_ff   <= rsp_valid_in;
         preroll_len_ff <= preroll_len_in;
         max_samples_ff <= max_samples_in;
      end
      op_ff         <= op_in;
      sample_ff     <= sample_in;
      last_ff       <= last_in;
      rindex_ff     <= rindex_in;
      res_rdata_ff  <= res_rdata_in;
      rsp_rdata_ff  <= rsp_rdata_in;
      rsp_count_ff  <= rsp_count_in;
      rsp_active_ff <= rsp_active_in;
      rsp_limit_ff  <= rsp_limit_in;
      rsp_listen_ff <= rsp_listen_in;
   end

   pscb_ring #(
      .PREROLL_DEPTH (PREROLL_DEPTH)
   ) u_ring (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ring_ctrl),
      .push_data  (sample_ff),
      .ring_len   (ring_len),
      .copy_total (copy_total),
      .rd_data    (ring_rd_data)
   );

   pscb_capture #(
      .CAPTURE_DEPTH (CAPTURE_DEPTH)
   ) u_capture (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (cap_ctrl),
      .wr_data    (cap_wr_data),
      .rd_index   (req_tdata[pscb_pkg::REQ_TDATA_W-1:pscb_pkg::SAMPLE_W]),
      .cap_limit  (cap_limit),
      .count      (cap_count),
      .count_next (cap_count_next),
      .room       (cap_room),
      .rd_data    (cap_rd_data)
   );

`ifndef SYNTHESIS
   // An accepted transaction is executed in the very next cycle.
   a_accept_exec: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> state_ff == ST_EXEC)
      else $error("accepted transaction not executed next cycle");

   // The ring is only walked while a copy for a new utterance is running.
   a_copy_recording: assert property (@(posedge clock) disable iff (reset)
      ring_ctrl.copy_step |-> (recording_ff && state_ff == ST_COPY))
      else $error("ring copy step outside a recording copy");

   // A sample goes either to the ring or to the capture memory, never both.
   a_one_target: assert property (@(posedge clock) disable iff (reset)
      !(ring_ctrl.push && cap_ctrl.write))
      else $error("sample pushed to ring and capture at once");

   // The captured count never passes the capture depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      cap_count <= CLW'(CAPTURE_DEPTH))
      else $error("captured count beyond capture depth");
`endif

endmodule
